/* design/stbs_pkg.sv */
// package with shared types and constants for the sorted table binary search
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_WIDTH_DEF   = 32;

  localparam int COUNT_W = 9;
  localparam int INDEX_W = 8;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;

  // input item
  typedef struct packed {
    logic                       mode;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [VALUE_W-1:0]  key_value;
  } item_t;

  // result item
  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  match_position;
  } result_t;

  // item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic wr;     // store entry from the accepted beat
    logic load;   // start a search with the accepted key
    logic probe;  // register mid and read the table
    logic step;   // compare and narrow the window
    logic emit;   // load the result register
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic open;   // window still holds entries
    logic hit;    // probed entry equals the key
  } sts_t;

endpackage

`default_nettype wire

/* design/stbs_ctrl.sv */
// controller state machine for the sorted table binary search
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl
  import stbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  output logic      item_ready,
  input  wire logic item_mode,
  output logic      result_valid,
  input  wire logic result_ready,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       result_valid_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next        = state;
    ctl               = '0;
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item_mode == MODE_WRITE) begin
            ctl.wr = 1'b1;
          end else begin
            ctl.load   = 1'b1;
            state_next = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (sts.open) begin
          ctl.probe  = 1'b1;
          state_next = S_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CMP: begin
        ctl.step   = 1'b1;
        state_next = sts.hit ? S_DONE : S_PROBE;
      end
      S_DONE: begin
        // wait for the result slot to drain
        if (!result_valid || result_ready) begin
          ctl.emit          = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

/* design/stbs_dpath.sv */
// datapath with key table, search window and result register
`timescale 1ns / 1ps
`default_nettype none

module stbs_dpath
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [COUNT_W-1:0] cfg_write_data,
  input  wire item_t              item,
  input  wire ctl_t               ctl,
  output sts_t                    sts,
  output result_t                 result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic signed [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];

  logic [COUNT_W-1:0]          entry_count;
  logic signed [KEY_WIDTH-1:0] key_reg;
  logic signed [KEY_WIDTH-1:0] rdata;
  logic [CNT_W-1:0]            first;
  logic [CNT_W-1:0]            last_excl;   // one past the last entry of the window
  logic [IDX_W-1:0]            mid;
  logic                        found_reg;

  logic signed [KEY_WIDTH-1:0] key_ext;
  logic [CNT_W-1:0]            count_sat;
  logic [CNT_W-1:0]            mid_calc;
  logic                        wr_ok;
  logic                        key_lt;

  assign key_ext   = KEY_WIDTH'(item.key_value);
  assign count_sat = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(entry_count);
  assign wr_ok     = 32'(item.entry_index) < 32'(TABLE_DEPTH);
  assign mid_calc  = first + ((last_excl - first - CNT_W'(1)) >> 1);
  assign key_lt    = key_reg < rdata;

  assign sts.open = first < last_excl;
  assign sts.hit  = (key_reg == rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write_en) begin
      entry_count <= cfg_write_data;
    end
  end

  // table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctl.wr && wr_ok) begin
      key_mem[IDX_W'(item.entry_index)] <= key_ext;
    end
    if (ctl.probe) begin
      rdata <= key_mem[mid_calc[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_reg   <= key_ext;
      first     <= '0;
      last_excl <= count_sat;
      found_reg <= 1'b0;
    end
    if (ctl.probe) begin
      mid <= mid_calc[IDX_W-1:0];
    end
    if (ctl.step) begin
      if (sts.hit) begin
        found_reg <= 1'b1;
      end else if (key_lt) begin
        last_excl <= CNT_W'(mid);
      end else begin
        first <= CNT_W'(mid) + CNT_W'(1);
      end
    end
    if (ctl.emit) begin
      result.found          <= found_reg;
      result.match_position <= found_reg ? POS_W'(mid) : '0;
    end
  end

endmodule

`default_nettype wire

/* design/sorted_table_binary_search.sv */
// top level of the sorted table binary search
//
// usage: software loads keys in ascending order with write beats on the
// item channel (mode write, entry_index, key_value); a write gives no result
// and a position beyond the table is dropped. cfg_write_en/cfg_write_data set
// the number of entries in use, saturated to the table depth; write it only
// while the block is idle.
// a search beat (mode search) returns one beat on the result channel with
// found and the matched position (zero when not found).
// a write leaves the block idle, so the next beat may follow at once.
// a search makes p probes (at most 9 for 256 entries), each a table read
// then a compare on the registered read data through the single read port;
// after a hit, or after a final probe state finds the window empty on a
// miss, the result shows in the same cycle as the next beat can be taken.
// item_ready drops for the whole search.
// the result sits in an output register; a stalled receiver holds it there
// while the next beat is accepted, and a finished search waits until the
// register drains.
// reset clears the state machine, the result valid flag and the entry count;
// the table content is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [COUNT_W-1:0] cfg_write_data,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire item_t              item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output result_t                 result
);

  // command and status between controller and datapath
  ctl_t ctl;
  sts_t sts;

  // sequencing of write and search beats, result handshake
  stbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_mode    (item.mode),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .ctl          (ctl)
  );

  // key table, window arithmetic and result payload
  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item           (item),
    .ctl            (ctl),
    .sts            (sts),
    .result         (result)
  );

endmodule

`default_nettype wire

/* design/stbs_checker.sv */
// port checker for the sorted table binary search, with its bind
`timescale 1ns / 1ps
`default_nettype none

module stbs_checker
  import stbs_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_ready,
  input wire item_t   item,
  input wire logic    result_valid,
  input wire logic    result_ready,
  input wire result_t result
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.match_position == '0)
    else $error("miss with non-zero position");

  // a write beat never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.mode == MODE_WRITE && !result_valid
    |=> !result_valid)
    else $error("result after write beat");

  // a search gives no result right away and blocks the item channel meanwhile
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.mode == MODE_SEARCH && !result_valid
    |=> !result_valid && !item_ready)
    else $error("search finished too early or item channel open");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

/* sim/testbench.sv */
// testbench for the sorted table binary search: writes tables, searches them, checks every lookup
`timescale 1ns / 1ps

module testbench;
  import stbs_pkg::*;

  localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BEATS   = 700;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [COUNT_W-1:0] cfg_write_data = '0;
  logic               item_valid = 1'b0;
  logic               item_ready;
  item_t              item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;

  // stimulus side: beats waiting for the driver, plus what the generator believes is stored
  item_t                     beats_to_send[$];
  int                        beats_queued = 0;
  logic signed [VALUE_W-1:0] plan_keys[TABLE_DEPTH_DEF];
  int                        live_count = 0;
  bit                        steady = 1'b0;

  // checking side: mirror of the block and the lookups still owed
  logic signed [VALUE_W-1:0] key_mirror[TABLE_DEPTH_DEF];
  logic [COUNT_W-1:0]        count_mirror = '0;
  result_t                   lookups_due[$];
  result_t                   want;
  int                        beats_taken = 0;
  int                        results_seen = 0;
  int                        fault_count = 0;

  int stall_left = 0;
  bit stall_done = 1'b0;
  int quiet_cycles = 0;

  sorted_table_binary_search u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result)
  );

  always #6 clk = ~clk;

  // binary search over the mirrored table with the mirrored count, saturated to the depth
  function automatic result_t predict_lookup(logic signed [VALUE_W-1:0] key);
    result_t r;
    int      span;
    int      lo;
    int      hi;
    int      mid;
    r    = '0;
    span = (count_mirror > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(count_mirror);
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi && !r.found) begin
      mid = lo + (hi - lo) / 2;
      if (key == key_mirror[mid]) begin
        r.found          = 1'b1;
        r.match_position = mid[POS_W-1:0];
      end else if (key < key_mirror[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  // driver: a new beat may go up once the previous one has been taken
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (beats_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 12)) begin
        item       <= beats_to_send.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, and once a long hold-off while the sender still has plenty queued
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (!stall_done && results_seen >= 40 && beats_queued - beats_taken > 8) begin
      stall_left   <= 400;
      stall_done   <= 1'b1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= steady || ($urandom_range(0, 99) >= 12);
    end
  end

  // monitor: update the mirror on accepted beats, check lookups in order
  always @(posedge clk) begin
    if (rst) begin
      count_mirror = '0;
    end else begin
      if (cfg_write_en)
        count_mirror = cfg_write_data;
      if (item_valid && item_ready) begin
        beats_taken <= beats_taken + 1;
        if (item.mode == MODE_WRITE)
          key_mirror[item.entry_index] = item.key_value;
        else
          lookups_due.push_back(predict_lookup(item.key_value));
      end
      if (result_valid && result_ready) begin
        results_seen <= results_seen + 1;
        if (lookups_due.size() == 0) begin
          $display("%0t unexpected lookup beat: expected none, actual found %0b position %0d",
                   $time, result.found, result.match_position);
          fault_count++;
        end else begin
          want = lookups_due.pop_front();
          if (result.found !== want.found) begin
            $display("%0t found mismatch: expected %0b, actual %0b",
                     $time, want.found, result.found);
            fault_count++;
          end
          if (result.match_position !== want.match_position) begin
            $display("%0t match_position mismatch: expected %0d, actual %0d",
                     $time, want.match_position, result.match_position);
            fault_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_write(int idx, logic signed [VALUE_W-1:0] v);
    item_t b;
    b.mode        = MODE_WRITE;
    b.entry_index = idx[INDEX_W-1:0];
    b.key_value   = v;
    beats_to_send.push_back(b);
    beats_queued++;
    plan_keys[idx] = v;
  endtask

  // entry_index carries junk on searches, the block should ignore it
  task automatic push_search(logic signed [VALUE_W-1:0] k);
    item_t b;
    b.mode        = MODE_SEARCH;
    b.entry_index = INDEX_W'($urandom_range(0, 255));
    b.key_value   = k;
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  // checked at the falling edge so the counters and queues have settled
  task automatic wait_idle();
    do @(negedge clk); while (beats_taken != beats_queued || lookups_due.size() != 0);
  endtask

  // a write beat gives no result, so wait_idle alone cannot see it land; pause before the update
  task automatic set_count(int unsigned v);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v[COUNT_W-1:0];
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
    live_count = (v > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(v);
  endtask

  // loads entries 0..n-1, ascending unless shuffled; tight strides give runs of duplicates
  task automatic fill_keys(int n, bit shuffled);
    longint      cur;
    int unsigned stride;
    int          i;
    stride = ($urandom_range(0, 2) == 0) ? 3 : 32'hFFFF_FFFF / (n + 1);
    cur    = longint'(KEY_MIN);
    if ($urandom_range(0, 3) != 0)
      cur += longint'($urandom_range(0, stride));
    for (i = 0; i < n; i++) begin
      if (shuffled) begin
        push_write(i, $urandom);
      end else begin
        if (cur > longint'(KEY_MAX))
          cur = longint'(KEY_MAX);
        push_write(i, cur[VALUE_W-1:0]);
        if ($urandom_range(0, 9) != 0)
          cur += longint'($urandom_range(0, stride)) + longint'($urandom_range(0, stride));
      end
    end
  endtask

  // mostly keys that are present, the rest near misses, random keys and the extremes
  task automatic pick_search(int span);
    logic signed [VALUE_W-1:0] k;
    int                        sel;
    sel = $urandom_range(0, 99);
    k   = plan_keys[$urandom_range(0, span - 1)];
    if (sel >= 95)
      k = sel[0] ? KEY_MAX : KEY_MIN;
    else if (sel >= 90)
      k = $urandom;
    else if (sel >= 75)
      k = k - 1;
    else if (sel >= 55)
      k = k + 1;
    push_search(k);
  endtask

  initial begin
    int phase;
    int n;
    int rounds;
    int i;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table straight out of reset: nothing may be probed
    push_search(32'sd0);

    // extremes of the key range, first with a single entry in use
    push_write(0, KEY_MIN);
    push_write(1, -32'sd1);
    push_write(2, 32'sd0);
    push_write(3, 32'sd1);
    push_write(4, KEY_MAX);
    set_count(1);
    push_search(KEY_MIN);
    push_search(KEY_MAX);

    // every entry hit, and misses just inside the extremes and either side of the middle keys
    set_count(5);
    push_search(KEY_MIN);
    push_search(-32'sd1);
    push_search(32'sd0);
    push_search(32'sd1);
    push_search(KEY_MAX);
    push_search(-32'sd2);
    push_search(32'sd2);
    push_search(KEY_MIN + 32'sd1);
    push_search(KEY_MAX - 32'sd1);

    // duplicate keys at the top end: the first one probed is reported
    push_write(5, KEY_MAX);
    push_write(6, KEY_MAX);
    push_write(7, KEY_MAX);
    set_count(8);
    push_search(KEY_MAX);

    // unsorted table: the probe sequence runs regardless
    push_write(2, KEY_MIN);
    push_search(KEY_MIN);
    push_search(32'sd0);

    // random phases: load a table, set the count, search it, with stray writes as noise
    phase = 0;
    while (beats_queued < RANDOM_BEATS + 24) begin
      wait_idle();
      steady = (phase == 4);
      if (phase == 2) begin
        fill_keys(TABLE_DEPTH_DEF, 1'b0);
        set_count(TABLE_DEPTH_DEF);
      end else if (phase == 3) begin
        // count beyond the depth saturates; the whole table is written by now
        set_count(511);
      end else if (phase > 3 && $urandom_range(0, 7) == 0) begin
        set_count($urandom_range(TABLE_DEPTH_DEF + 1, 510));
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 128) : $urandom_range(1, 32);
        fill_keys(n, $urandom_range(0, 4) == 0);
        set_count(n);
      end
      rounds = $urandom_range(10, 40);
      for (i = 0; i < rounds; i++) begin
        if ($urandom_range(0, 99) < 8)
          push_write($urandom_range(0, TABLE_DEPTH_DEF - 1), $urandom);
        else
          pick_search(live_count);
      end
      phase++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fault_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
